### rtl/core/xcrx_pkg.sv
`default_nettype none

package xcrx_pkg;

   localparam int unsigned PACKET_BYTES         = 128;
   localparam int unsigned PACKET_WORDS         = PACKET_BYTES / 4;
   localparam int unsigned WORD_AW              = $clog2(PACKET_WORDS);
   localparam int unsigned MAX_PACKETS_PER_PAGE = 32;

   localparam logic [7:0]  POS_DATA_FIRST = 8'd3;
   localparam logic [7:0]  POS_DATA_LAST  = 8'd130;
   localparam logic [7:0]  POS_CRC_HI     = 8'd131;
   localparam logic [7:0]  POS_CRC_LO     = 8'd132;
   localparam logic [7:0]  POS_FIRST      = 8'd0;
   localparam logic [7:0]  POS_MAX        = 8'd255;
   localparam logic [7:0]  BYTE_SOH       = 8'h01;
   localparam logic [7:0]  BYTE_EOT       = 8'h04;
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [15:0] CRC_INIT       = 16'h0000;

   localparam logic CSR_BASE_ADDRESS     = 1'b0;
   localparam logic CSR_PACKETS_PER_PAGE = 1'b1;

   typedef enum logic [2:0] {
      KIND_ACK    = 3'd0,
      KIND_NAK    = 3'd1,
      KIND_WORD   = 3'd2,
      KIND_COMMIT = 3'd3,
      KIND_RESET  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      DEC_NONE,
      DEC_PACKET,
      DEC_NAK,
      DEC_EOT
   } dec_type;

   typedef struct packed {
      logic     accept;
      logic     word_next;
      logic     load;
      kind_type kind;
      logic     last;
   } cmd_type;

   typedef struct packed {
      dec_type dec;
      logic    commit_flag;
      logic    word_last;
   } status_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/core/xcrx_ram.sv
`default_nettype none

module xcrx_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/xcrx_datapath.sv
`default_nettype none

module xcrx_datapath
   import xcrx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_frame_end,
   input  wire logic        csr_valid,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data,
   input  wire cmd_type     cmd,
   output status_type       status,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_address,
   output logic [31:0]      rsp_word,
   output logic [12:0]      rsp_length,
   output logic             rsp_last
);

   logic [31:0]        base_ff;
   logic [5:0]         ppp_ff;
   logic               session_ff;
   logic [15:0]        pc_ff;
   logic [4:0]         pip_ff;
   logic [7:0]         idx_ff;
   logic [7:0]         first_ff;
   logic [15:0]        crc_ff;
   logic [7:0]         rcv_hi_ff;
   logic [23:0]        sh_ff;
   logic [WORD_AW-1:0] word_ff;
   logic [31:0]        pkt_addr_ff;
   logic [31:0]        cmt_addr_ff;
   logic [12:0]        cmt_len_ff;
   logic               cmt_flag_ff;

   logic [5:0]         page_size;
   dec_type            dec;
   logic               is_pkt;
   logic [15:0]        pc_in;
   logic [5:0]         cnt;
   logic [15:0]        first_pkt;
   logic [31:0]        cmt_addr_in;
   logic               cmt_flag_in;
   logic               in_data;
   logic [6:0]         offset;
   logic               ram_wr;
   logic [31:0]        ram_q;

   always_comb begin
      if (ppp_ff == 6'd0) begin
         page_size = 6'd1;
      end else if (ppp_ff > 6'(MAX_PACKETS_PER_PAGE)) begin
         page_size = 6'(MAX_PACKETS_PER_PAGE);
      end else begin
         page_size = ppp_ff;
      end
   end

   always_comb begin
      dec = DEC_NONE;
      if (!req_op && req_frame_end && session_ff) begin
         if (idx_ff == POS_CRC_LO && first_ff == BYTE_SOH) begin
            dec = (crc_ff == {rcv_hi_ff, req_data_byte}) ? DEC_PACKET : DEC_NAK;
         end else if (idx_ff == POS_FIRST && req_data_byte == BYTE_EOT) begin
            dec = DEC_EOT;
         end
      end
   end

   assign is_pkt      = (dec == DEC_PACKET);
   assign pc_in       = pc_ff + {15'd0, is_pkt};
   assign cnt         = {1'b0, pip_ff} + {5'd0, is_pkt};
   assign first_pkt   = pc_in - {10'd0, cnt};
   assign cmt_addr_in = base_ff + {9'd0, first_pkt, 7'd0};
   assign cmt_flag_in = is_pkt ? (cnt >= page_size) : (pip_ff != 5'd0);

   assign in_data = (idx_ff >= POS_DATA_FIRST) && (idx_ff <= POS_DATA_LAST);
   assign offset  = 7'(idx_ff - POS_DATA_FIRST);
   assign ram_wr  = cmd.accept && !req_op && in_data && (offset[1:0] == 2'b11);

   xcrx_ram #(
      .WIDTH(32),
      .DEPTH(PACKET_WORDS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(offset[6:2]),
      .wr_data({req_data_byte, sh_ff}),
      .rd_addr(word_ff),
      .rd_data(ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= 32'd0;
         ppp_ff     <= 6'd8;
         session_ff <= 1'b0;
         pc_ff      <= 16'd0;
         pip_ff     <= 5'd0;
         idx_ff     <= 8'd0;
         first_ff   <= 8'd0;
         crc_ff     <= CRC_INIT;
         rcv_hi_ff  <= 8'd0;
         word_ff    <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BASE_ADDRESS:     base_ff <= csr_data;
               CSR_PACKETS_PER_PAGE: ppp_ff  <= csr_data[5:0];
               default:              ;
            endcase
         end
         if (cmd.accept) begin
            word_ff <= '0;
            if (req_op) begin
               session_ff <= 1'b1;
               pc_ff      <= 16'd0;
               pip_ff     <= 5'd0;
               idx_ff     <= 8'd0;
               crc_ff     <= CRC_INIT;
               rcv_hi_ff  <= 8'd0;
            end else begin
               if (idx_ff == POS_FIRST) begin
                  first_ff <= req_data_byte;
               end
               if (in_data) begin
                  crc_ff <= crc_byte(crc_ff, req_data_byte);
               end
               if (idx_ff == POS_CRC_HI) begin
                  rcv_hi_ff <= req_data_byte;
               end
               if (req_frame_end) begin
                  idx_ff    <= 8'd0;
                  crc_ff    <= CRC_INIT;
                  rcv_hi_ff <= 8'd0;
               end else if (idx_ff != POS_MAX) begin
                  idx_ff <= idx_ff + 8'd1;
               end
               if (dec == DEC_PACKET) begin
                  pc_ff  <= pc_in;
                  pip_ff <= cmt_flag_in ? 5'd0 : cnt[4:0];
               end else if (dec == DEC_EOT) begin
                  pip_ff     <= 5'd0;
                  session_ff <= 1'b0;
               end
            end
         end else if (cmd.word_next) begin
            word_ff <= word_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !req_op) begin
         if (in_data) begin
            sh_ff <= {req_data_byte, sh_ff[23:8]};
         end
         if (dec != DEC_NONE) begin
            pkt_addr_ff <= base_ff + {9'd0, pc_ff, 7'd0};
            cmt_addr_ff <= cmt_addr_in;
            cmt_len_ff  <= {cnt, 7'd0};
            cmt_flag_ff <= cmt_flag_in;
         end
      end
      if (cmd.load) begin
         rsp_kind    <= cmd.kind;
         rsp_last    <= cmd.last;
         rsp_address <= 32'd0;
         rsp_word    <= 32'd0;
         rsp_length  <= 13'd0;
         case (cmd.kind)
            KIND_WORD: begin
               rsp_address <= pkt_addr_ff + {25'd0, word_ff, 2'b00};
               rsp_word    <= ram_q;
            end
            KIND_COMMIT: begin
               rsp_address <= cmt_addr_ff;
               rsp_length  <= cmt_len_ff;
            end
            default: ;
         endcase
      end
   end

   assign status.dec         = dec;
   assign status.commit_flag = cmt_flag_ff;
   assign status.word_last   = (word_ff == '1);

endmodule

`default_nettype wire

### rtl/core/xcrx_ctrl.sv
`default_nettype none

module xcrx_ctrl
   import xcrx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_WORD,
      S_PKT_COMMIT,
      S_PKT_ACK,
      S_NAK,
      S_EOT_ACK,
      S_EOT_COMMIT,
      S_EOT_RESET
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.word_next = 1'b0;
      cmd.load      = 1'b0;
      cmd.kind      = KIND_ACK;
      cmd.last      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               unique case (status.dec)
                  DEC_PACKET: state_in = S_READ;
                  DEC_NAK:    state_in = S_NAK;
                  DEC_EOT:    state_in = S_EOT_ACK;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_READ: state_in = S_WORD;
         S_WORD: begin
            cmd.kind = KIND_WORD;
            if (out_free) begin
               cmd.load = 1'b1;
               if (status.word_last) begin
                  state_in = status.commit_flag ? S_PKT_COMMIT : S_PKT_ACK;
               end else begin
                  cmd.word_next = 1'b1;
                  state_in      = S_READ;
               end
            end
         end
         S_PKT_COMMIT: begin
            cmd.kind = KIND_COMMIT;
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_PKT_ACK;
            end
         end
         S_PKT_ACK: begin
            cmd.kind = KIND_ACK;
            cmd.last = 1'b1;
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_NAK: begin
            cmd.kind = KIND_NAK;
            cmd.last = 1'b1;
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_EOT_ACK: begin
            cmd.kind = KIND_ACK;
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = status.commit_flag ? S_EOT_COMMIT : S_EOT_RESET;
            end
         end
         S_EOT_COMMIT: begin
            cmd.kind = KIND_COMMIT;
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_EOT_RESET;
            end
         end
         S_EOT_RESET: begin
            cmd.kind = KIND_RESET;
            cmd.last = 1'b1;
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/xmodem_crc_packet_receiver.sv
// Channel   Direction  Handshake          Payload
// req_      in         valid / stall      op, data_byte, frame_end
// rsp_      out        valid / stall      kind, address, word, length, last
// csr_      in         valid / ready      index (0 base, 1 page size), data
//
// One frame byte is taken per cycle while no result burst is pending.
// A good packet gives 32 word writes from the packet store read port, each
// through a read and a word state, then the further results; all may stall.
// Reset is synchronous and clears the session, the counters and the CRC.
// Input is stalled for the whole of a burst; results are held while stalled.
`default_nettype none

module xmodem_crc_packet_receiver
   import xcrx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_frame_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_address,
   output logic [31:0]      rsp_word,
   output logic [12:0]      rsp_length,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   xcrx_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   xcrx_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_op       (req_op),
      .req_data_byte(req_data_byte),
      .req_frame_end(req_frame_end),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_kind     (rsp_kind),
      .rsp_address  (rsp_address),
      .rsp_word     (rsp_word),
      .rsp_length   (rsp_length),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

### rtl/core/xcrx_checker.sv
`default_nettype none

module xcrx_checker
   import xcrx_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_kind,
   input wire logic [31:0] rsp_address,
   input wire logic [31:0] rsp_word,
   input wire logic [12:0] rsp_length,
   input wire logic        rsp_last
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_address)
         && $stable(rsp_word) && $stable(rsp_length) && $stable(rsp_last))
      else $error("stalled result item changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_RESET || rsp_kind == KIND_NAK) |-> rsp_last)
      else $error("session end or NAK item is not the last of its burst");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_WORD |-> !rsp_last && rsp_length == 13'd0)
      else $error("word write item marked last or with a length");

endmodule

bind xmodem_crc_packet_receiver xcrx_checker u_xcrx_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_kind   (rsp_kind),
   .rsp_address(rsp_address),
   .rsp_word   (rsp_word),
   .rsp_length (rsp_length),
   .rsp_last   (rsp_last)
);

`default_nettype wire
